// ----- src/iirdf1_pkg.sv -----
// Shared types, constants and the microcode program of the direct form I IIR filter.
package iirdf1_pkg;

    // Field and arithmetic widths.
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 18;
    localparam int COEF_FRAC_BITS = 14;
    localparam int ORDER          = 3;
    localparam int NUM_REGS       = 7;
    localparam int REG_IDX_W      = $clog2(NUM_REGS);
    localparam int PROD_W         = COEF_W + SAMPLE_W;
    // Seven products need three guard bits; one more keeps the rounding add safe.
    localparam int ACC_W          = PROD_W + 4;
    localparam int SHIFT_W        = ACC_W - COEF_FRAC_BITS;
    localparam int STEP_W         = 4;

    // Coefficient reset value: 1.0 for the current-input tap.
    localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << COEF_FRAC_BITS;
    // Half an output LSB, used for round half up.
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // Coefficient register indexes.
    localparam logic [REG_IDX_W-1:0] REG_FF0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FF1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_FF2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_FF3 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_FB1 = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_FB2 = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_FB3 = REG_IDX_W'(6);

    // Multiplier data operand source.
    typedef enum logic [2:0] {
        SRC_X,
        SRC_XH0,
        SRC_XH1,
        SRC_XH2,
        SRC_YH0,
        SRC_YH1,
        SRC_YH2
    } t_src;

    // What the accumulator does with the product registered in the previous step.
    typedef enum logic [1:0] {
        ACC_NOP,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    // Sequencing of a step: go on to the next one, or wait for a free output and end.
    typedef enum logic {
        JMP_NEXT,
        JMP_WAIT_OUT
    } t_jmp;

    // Sequencer state.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // One microcode word.
    typedef struct packed {
        logic [REG_IDX_W-1:0] coef_sel;
        t_src                 src;
        t_acc_op              acc;
        logic                 wb;
        t_jmp                 jmp;
    } t_uword;

    // Control from the sequencer to the datapath for the current cycle.
    typedef struct packed {
        logic                 load_x;
        logic [REG_IDX_W-1:0] coef_sel;
        t_src                 src;
        t_acc_op              acc;
        logic                 wb;
    } t_ctrl;

    // Accumulate a product only when its tap lies within the filter order.
    function automatic t_acc_op tap_op(input int tap, input t_acc_op op);
        return (tap <= ORDER) ? op : ACC_NOP;
    endfunction

    // The program: each step issues one multiply and folds in the product of
    // the step before. Feedback products are subtracted.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w.coef_sel = REG_FF0;
        w.src      = SRC_X;
        w.acc      = ACC_NOP;
        w.wb       = 1'b0;
        w.jmp      = JMP_NEXT;
        case (step)
            STEP_W'(0): begin
                w.coef_sel = REG_FF0;
                w.src      = SRC_X;
            end
            STEP_W'(1): begin
                w.coef_sel = REG_FF1;
                w.src      = SRC_XH0;
                w.acc      = ACC_LOAD;
            end
            STEP_W'(2): begin
                w.coef_sel = REG_FB1;
                w.src      = SRC_YH0;
                w.acc      = tap_op(1, ACC_ADD);
            end
            STEP_W'(3): begin
                w.coef_sel = REG_FF2;
                w.src      = SRC_XH1;
                w.acc      = tap_op(1, ACC_SUB);
            end
            STEP_W'(4): begin
                w.coef_sel = REG_FB2;
                w.src      = SRC_YH1;
                w.acc      = tap_op(2, ACC_ADD);
            end
            STEP_W'(5): begin
                w.coef_sel = REG_FF3;
                w.src      = SRC_XH2;
                w.acc      = tap_op(2, ACC_SUB);
            end
            STEP_W'(6): begin
                w.coef_sel = REG_FB3;
                w.src      = SRC_YH2;
                w.acc      = tap_op(3, ACC_ADD);
            end
            STEP_W'(7): begin
                w.acc      = tap_op(3, ACC_SUB);
            end
            STEP_W'(8): begin
                w.wb       = 1'b1;
                w.jmp      = JMP_WAIT_OUT;
            end
            default: begin
                w.jmp      = JMP_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/iirdf1_seq.sv -----
// Microcode sequencer: step counter, program table and end-of-program jump.
module iirdf1_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_out_free,
    output logic                o_busy,
    output iirdf1_pkg::t_ctrl   o_ctrl
);
    import iirdf1_pkg::*;

    t_seq_state        r_state;
    t_seq_state        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            word;

    assign word   = ucode(r_step);
    assign o_busy = (r_state == SEQ_RUN);

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Decode the current word into datapath control and pick the next step.
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_ctrl.load_x   = 1'b0;
        o_ctrl.coef_sel = REG_FF0;
        o_ctrl.src      = SRC_X;
        o_ctrl.acc      = ACC_NOP;
        o_ctrl.wb       = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    o_ctrl.load_x = 1'b1;
                    n_state       = SEQ_RUN;
                    n_step        = '0;
                end
            end
            SEQ_RUN: begin
                o_ctrl.coef_sel = word.coef_sel;
                o_ctrl.src      = word.src;
                o_ctrl.acc      = word.acc;
                unique case (word.jmp)
                    JMP_NEXT: begin
                        n_step = r_step + STEP_W'(1);
                    end
                    JMP_WAIT_OUT: begin
                        // Hold on this step until the output register can take the result.
                        if (i_out_free) begin
                            o_ctrl.wb = word.wb;
                            n_state   = SEQ_IDLE;
                            n_step    = '0;
                        end
                    end
                    default: begin
                        n_step = r_step;
                    end
                endcase
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

endmodule

// ----- src/iirdf1_datapath.sv -----
// Datapath: coefficient registers, histories, shared multiplier, accumulator, round and saturate.
module iirdf1_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  iirdf1_pkg::t_ctrl                      i_ctrl,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                   i_cfg_we,
    input  logic [iirdf1_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]          i_cfg_data,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] o_result,
    output logic                                   o_clipped
);
    import iirdf1_pkg::*;

    logic signed [COEF_W-1:0]   r_coef [NUM_REGS];
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_xh [3];
    logic signed [SAMPLE_W-1:0] r_yh [3];
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [COEF_W-1:0]   coef_op;
    logic signed [SAMPLE_W-1:0] data_op;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [SHIFT_W-1:0]  shifted;
    logic [SHIFT_W-SAMPLE_W:0]  top_bits;

    // Coefficient registers; writes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= (i == int'(REG_FF0)) ? COEF_ONE : '0;
            end
        end else if (i_cfg_we && (i_cfg_index <= REG_FB3)) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // Coefficient operand select.
    always_comb begin
        unique case (i_ctrl.coef_sel)
            REG_FF0: coef_op = r_coef[REG_FF0];
            REG_FF1: coef_op = r_coef[REG_FF1];
            REG_FF2: coef_op = r_coef[REG_FF2];
            REG_FF3: coef_op = r_coef[REG_FF3];
            REG_FB1: coef_op = r_coef[REG_FB1];
            REG_FB2: coef_op = r_coef[REG_FB2];
            REG_FB3: coef_op = r_coef[REG_FB3];
            default: coef_op = '0;
        endcase
    end

    // Data operand select.
    always_comb begin
        unique case (i_ctrl.src)
            SRC_X:   data_op = r_x;
            SRC_XH0: data_op = r_xh[0];
            SRC_XH1: data_op = r_xh[1];
            SRC_XH2: data_op = r_xh[2];
            SRC_YH0: data_op = r_yh[0];
            SRC_YH1: data_op = r_yh[1];
            SRC_YH2: data_op = r_yh[2];
            default: data_op = '0;
        endcase
    end

    // Current sample capture.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= i_sample;
        end
    end

    // Shared multiplier with a product register.
    always_ff @(posedge i_clk) begin
        r_prod <= coef_op * data_op;
    end

    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Accumulator folds in the product of the previous step.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.acc)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_ADD:  r_acc <= r_acc + prod_ext;
            ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    // Round half up, then drop the fraction bits with an arithmetic shift.
    assign rounded  = r_acc + $signed(ROUND_HALF);
    assign shifted  = rounded[ACC_W-1:COEF_FRAC_BITS];
    assign top_bits = shifted[SHIFT_W-1:SAMPLE_W-1];

    // Saturate when the bits above the sample's sign bit are not a pure sign extension.
    always_comb begin
        o_clipped = !((&top_bits) || (~|top_bits));
        if (o_clipped) begin
            o_result = shifted[SHIFT_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                          : {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end else begin
            o_result = shifted[SAMPLE_W-1:0];
        end
    end

    // Input and output histories, newest first; the saturated result is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else if (i_ctrl.wb) begin
            r_xh[2] <= r_xh[1];
            r_xh[1] <= r_xh[0];
            r_xh[0] <= r_x;
            r_yh[2] <= r_yh[1];
            r_yh[1] <= r_yh[0];
            r_yh[0] <= o_result;
        end
    end

endmodule

// ----- src/iir_filter_direct_form_one.sv -----
// Top level of the third-order direct form I IIR filter with stream ports.
// One sample in gives one sample out. A sample is accepted only while the
// microcode sequencer is idle; nine program steps then drive the single shared
// 18 x 16 multiplier and the accumulator through the seven taps, and the last
// step rounds, saturates, updates the histories and loads the output register.
// A sample is taken only after the program ends; the writeback step holds while the
// output register holds an untaken result, so a downstream stall holds off the next
// sample. The user must write coefficients through the plain write port only while
// no sample is in flight; the block itself does not enforce this.
module iir_filter_direct_form_one (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream; tdata: sample_in[15:0].
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] i_s_axis_tdata,
    // Output stream; tdata: sample_out[15:0]; tuser: clipped[0].
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] o_m_axis_tdata,
    output logic                                   o_m_axis_tuser,
    // Coefficient write port.
    input  logic                                   i_cfg_we,
    input  logic [iirdf1_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]          i_cfg_data
);
    import iirdf1_pkg::*;

    t_ctrl                      ctrl;
    logic                       busy;
    logic                       s_accept;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] result;
    logic                       clipped;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_clip;

    assign o_s_axis_tready = !busy;
    assign s_accept        = i_s_axis_tvalid && !busy;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    iirdf1_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    iirdf1_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_sample    (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result),
        .o_clipped   (clipped)
    );

    // Output register valid flag: set on writeback, cleared when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.wb) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (ctrl.wb) begin
            r_out_sample <= result;
            r_out_clip   <= clipped;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sample;
    assign o_m_axis_tuser  = r_out_clip;

`ifndef SYNTHESIS
    // An accepted sample starts the program.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> busy)
        else $error("sample accepted but sequencer did not start");

    // Writeback never overwrites a result that is not being taken.
    a_wb_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.wb |-> (!r_out_valid || i_m_axis_tready))
        else $error("writeback while output register is full");

    // Writeback presents a beat on the next cycle.
    a_wb_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.wb |=> o_m_axis_tvalid)
        else $error("writeback did not produce an output beat");

    // A clipped beat carries a full-scale value.
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (o_m_axis_tdata == 16'sh7fff || o_m_axis_tdata == -16'sh8000))
        else $error("clipped beat is not a full-scale value");
`endif

endmodule

// ----- sim/tb_iir_filter_direct_form_one.sv -----
// Self-checking testbench for the third-order direct form I IIR filter.
module tb_iir_filter_direct_form_one;
    timeunit 1ns;
    timeprecision 1ps;

    import iirdf1_pkg::*;

    // Write index past the last coefficient register; the block must ignore it.
    localparam logic [REG_IDX_W-1:0] NO_REG_IDX = REG_IDX_W'(NUM_REGS);
    localparam longint SAMPLE_MAX   = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN   = -(longint'(1) << (SAMPLE_W - 1));
    localparam int     IDLE_PERCENT = 11;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     QUIET_LIMIT  = 2000;
    localparam int     PHASE_ITEMS  = 100;
    localparam int     SHOWN_ERRORS = 10;

    // How a random coefficient set is drawn.
    typedef enum {
        COEF_FULL,
        COEF_MILD,
        COEF_FIR,
        COEF_EDGE
    } t_coef_profile;

    // One filtered sample as the block should deliver it.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_filt_out;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic                        o_s_axis_tready;
    logic signed [SAMPLE_W-1:0]  i_s_axis_tdata = '0;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_m_axis_tdata;
    logic                        o_m_axis_tuser;
    logic                        i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]        i_cfg_index = '0;
    logic [COEF_W-1:0]           i_cfg_data = '0;

    // Filter state as the block should hold it.
    logic signed [COEF_W-1:0]    coef_model [NUM_REGS];
    logic signed [SAMPLE_W-1:0]  x_hist [ORDER];
    logic signed [SAMPLE_W-1:0]  y_hist [ORDER];
    logic [COEF_W-1:0]           coef_plan [NUM_REGS];

    t_filt_out                   pending_outputs [$];
    int unsigned                 mismatches = 0;
    bit                          steady = 1'b0;
    int unsigned                 hold_requests = 0;
    int unsigned                 hold_seen = 0;
    int unsigned                 hold_left = 0;

    iir_filter_direct_form_one i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Filter one sample through the expected state and advance the histories.
    function automatic t_filt_out predict_filter_output(input logic signed [SAMPLE_W-1:0] x);
        longint    acc;
        longint    y;
        t_filt_out r;
        acc = longint'(coef_model[REG_FF0]) * longint'(x);
        for (int k = 1; k <= ORDER; k++) begin
            acc += longint'(coef_model[REG_FF0 + k]) * longint'(x_hist[k-1]);
            acc -= longint'(coef_model[REG_FB1 + k - 1]) * longint'(y_hist[k-1]);
        end
        // Round half toward plus infinity, then saturate.
        y = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        r.clipped = 1'b0;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            r.clipped = 1'b1;
        end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
            r.clipped = 1'b1;
        end
        r.sample = y[SAMPLE_W-1:0];
        for (int k = ORDER - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = r.sample;
        return r;
    endfunction

    // Mostly full-range samples, with the rails and small values mixed in.
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return SAMPLE_W'($signed(10'($urandom)));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample, idling at random first, and record its expected output.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_outputs.push_back(predict_filter_output(s));
    endtask

    // Stop offering and wait until every expected output has come back.
    task automatic drain_outputs();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx < NUM_REGS)
            coef_model[idx] = val;
    endtask

    // Write the whole coefficient plan, then release the write enable.
    task automatic apply_coef_plan();
        for (int r = 0; r < NUM_REGS; r++)
            write_coef(REG_IDX_W'(r), coef_plan[r]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_coef_plan(input t_coef_profile p);
        for (int r = 0; r < NUM_REGS; r++) begin
            case (p)
                COEF_FULL: coef_plan[r] = COEF_W'($urandom);
                COEF_MILD: coef_plan[r] = COEF_W'($signed(14'($urandom)));
                COEF_FIR:  coef_plan[r] = (r < REG_FB1) ? COEF_W'($signed(16'($urandom))) : '0;
                default: begin
                    case ($urandom_range(2))
                        0: coef_plan[r] = {1'b0, {(COEF_W-1){1'b1}}};
                        1: coef_plan[r] = {1'b1, {(COEF_W-1){1'b0}}};
                        default: coef_plan[r] = '0;
                    endcase
                end
            endcase
        end
    endtask

    // Default coefficients pass samples straight through.
    task automatic test_default_passthrough();
        send_sample(16'sh0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain_outputs();
    endtask

    // Half-LSB rounding, then every tap at its extreme to clip both ways.
    task automatic test_rounding_and_clipping();
        fill_coef_plan(COEF_FIR);
        for (int r = 0; r < NUM_REGS; r++)
            coef_plan[r] = '0;
        coef_plan[REG_FF0] = COEF_W'(1) << (COEF_FRAC_BITS - 1);
        apply_coef_plan();
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh0003);
        send_sample(16'shFFFD);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_outputs();

        coef_plan[REG_FF0] = {1'b0, {(COEF_W-1){1'b1}}};
        coef_plan[REG_FF1] = {1'b1, {(COEF_W-1){1'b0}}};
        coef_plan[REG_FF2] = {1'b0, {(COEF_W-1){1'b1}}};
        coef_plan[REG_FF3] = {1'b1, {(COEF_W-1){1'b0}}};
        coef_plan[REG_FB1] = {1'b1, {(COEF_W-1){1'b0}}};
        coef_plan[REG_FB2] = {1'b0, {(COEF_W-1){1'b1}}};
        coef_plan[REG_FB3] = {1'b1, {(COEF_W-1){1'b0}}};
        // A write past the last register must leave the coefficients alone.
        write_coef(NO_REG_IDX, COEF_W'($urandom));
        apply_coef_plan();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0064);
        send_sample(16'shFF9C);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        drain_outputs();
    endtask

    // Random samples under several coefficient sets; one phase runs without idling.
    task automatic test_filter_random();
        t_coef_profile p;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: p = COEF_FULL;
                1: p = COEF_MILD;
                2: p = COEF_FIR;
                3: p = COEF_EDGE;
                default: p = COEF_MILD;
            endcase
            steady = (phase == 1);
            fill_coef_plan(p);
            if ($urandom_range(1))
                write_coef(NO_REG_IDX, COEF_W'($urandom));
            apply_coef_plan();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample());
            drain_outputs();
        end
        steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_stall();
        fill_coef_plan(COEF_MILD);
        apply_coef_plan();
        send_sample(random_sample());
        hold_requests++;
        for (int n = 1; n < PHASE_ITEMS; n++)
            send_sample(random_sample());
        drain_outputs();
    endtask

    // Output side ready, with random stalls and the requested long hold-off.
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each output beat with the oldest expected sample.
    always @(posedge i_clk) begin : output_checker
        t_filt_out want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("ERROR: unexpected output beat: sample %0d clipped %0b",
                             o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = pending_outputs.pop_front();
                if (o_m_axis_tdata !== want.sample || o_m_axis_tuser !== want.clipped) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("ERROR: expected sample %0d clipped %0b, got %0d clipped %0b",
                                 want.sample, want.clipped, o_m_axis_tdata, o_m_axis_tuser);
                end
            end
        end
    end

    // End the run when nothing is accepted on any port for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        for (int r = 0; r < NUM_REGS; r++)
            coef_model[r] = '0;
        coef_model[REG_FF0] = COEF_ONE;
        for (int k = 0; k < ORDER; k++) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_passthrough();
        test_rounding_and_clipping();
        test_filter_random();
        test_output_stall();

        drain_outputs();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/iirdf1_pkg.sv
src/iirdf1_seq.sv
src/iirdf1_datapath.sv
src/iir_filter_direct_form_one.sv
sim/tb_iir_filter_direct_form_one.sv
